// ===== rtl/waist_motor_ramp_pd_controller_core_defines.svh =====
// Assertion helpers used by the core file, which checks its own logic.
`ifndef WAIST_MOTOR_RAMP_PD_CONTROLLER_CORE_DEFINES_SVH
`define WAIST_MOTOR_RAMP_PD_CONTROLLER_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define WMR_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define WMR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/wmr_pkg.sv =====
`timescale 1ns / 1ps

package wmr_pkg;

    // Field widths fixed by the item format.
    localparam int DATA_W  = 32;
    localparam int LIMIT_W = 31;
    localparam int DT_W    = 16;
    localparam int FUNC_W  = 3;
    localparam int KIND_W  = 2;
    localparam int CFG_IDX_W = 3;

    // Shared multiplier operand and product widths.
    localparam int MUL_A_W = 32;
    localparam int MUL_B_W = 34;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    localparam logic signed [DATA_W-1:0] MAX32 = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] MIN32 = 32'sh8000_0000;

    // Mode commands.
    typedef enum logic [FUNC_W-1:0] {
        FUNC_UP      = 3'd0,
        FUNC_DOWN    = 3'd1,
        FUNC_STOP    = 3'd2,
        FUNC_ZERO    = 3'd3,
        FUNC_DIRECT  = 3'd4,
        FUNC_TIMEOUT = 3'd5,
        FUNC_UNKNOWN = 3'd6
    } t_func;

    // Commanded direction of travel.
    typedef enum logic [1:0] {
        DIR_NONE = 2'd0,
        DIR_UP   = 2'd1,
        DIR_DOWN = 2'd2
    } t_dir;

    // Kind of motor command in a result item.
    typedef enum logic [KIND_W-1:0] {
        KIND_HALT    = 2'd0,
        KIND_RELEASE = 2'd1,
        KIND_CURRENT = 2'd2
    } t_kind;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_POSITION_GAIN  = 3'd0,
        CFG_DAMPING_GAIN   = 3'd1,
        CFG_GRAVITY_OFFSET = 3'd2,
        CFG_DRIVE_LIMIT    = 3'd3,
        CFG_SPEED_LIMIT    = 3'd4
    } t_cfg_idx;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_IDLE  = 3'd0,
        S_RAMP  = 3'd1,
        S_POS   = 3'd2,
        S_ERR_P = 3'd3,
        S_ERR_D = 3'd4,
        S_SUM   = 3'd5,
        S_CLAMP = 3'd6,
        S_FIN   = 3'd7
    } t_state;

endpackage

// ===== rtl/wmr_if.sv =====
`timescale 1ns / 1ps

// Input item channel: one control tick.
interface wmr_in_if;
    logic                                valid;
    logic                                ready;
    logic [wmr_pkg::FUNC_W-1:0]          func;
    logic signed [wmr_pkg::DATA_W-1:0]   direct_current;
    logic                                sample_valid;
    logic signed [wmr_pkg::DATA_W-1:0]   position_in;
    logic signed [wmr_pkg::DATA_W-1:0]   velocity_in;
    logic [wmr_pkg::DT_W-1:0]            time_step;

    modport source (output valid, func, direct_current, sample_valid, position_in,
                    velocity_in, time_step, input ready);
    modport sink (input valid, func, direct_current, sample_valid, position_in,
                  velocity_in, time_step, output ready);
endinterface

// Result item channel: one motor command.
interface wmr_out_if;
    logic                                valid;
    logic                                ready;
    logic [wmr_pkg::KIND_W-1:0]          command_kind;
    logic signed [wmr_pkg::DATA_W-1:0]   drive_a;
    logic signed [wmr_pkg::DATA_W-1:0]   drive_b;

    modport source (output valid, command_kind, drive_a, drive_b, input ready);
    modport sink (input valid, command_kind, drive_a, drive_b, output ready);
endinterface

// Configuration write channel.
interface wmr_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [wmr_pkg::CFG_IDX_W-1:0]       index;
    logic [wmr_pkg::DATA_W-1:0]          data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/waist_motor_ramp_pd_controller_core.sv =====
// Ramp-mode items run RAMP, POS, ERR_P, ERR_D, SUM, CLAMP, then FIN registers the result.
// Direct and zero-drive items go from IDLE straight to FIN; FIN holds while the output is full.
// Only IDLE takes a new item. One shared multiplier serves three dependent products in turn.
// A result waits in the output register while the next item is accepted and computed.
// Synchronous active-low reset restores all mode state, targets and configuration defaults.
`timescale 1ns / 1ps

`include "waist_motor_ramp_pd_controller_core_defines.svh"

module waist_motor_ramp_pd_controller_core #(
    parameter int FRAC_BITS = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    wmr_in_if.sink        i_in,
    wmr_out_if.source     o_out,
    wmr_cfg_if.sink       i_cfg
);

    localparam int DW      = wmr_pkg::DATA_W;
    localparam int SHIFT_W = wmr_pkg::MUL_P_W - FRAC_BITS;
    localparam int SUM_W   = SHIFT_W + 1;

    // Reset values and constants at the chosen fraction width.
    localparam longint GRAV_L = ((longint'(1027) << FRAC_BITS) + 64'sd500) / 64'sd1000;
    localparam logic signed [DW-1:0] RST_DAMPING = 32'(longint'(10) << FRAC_BITS);
    localparam logic signed [DW-1:0] RST_GRAVITY = 32'(GRAV_L);
    localparam logic [wmr_pkg::LIMIT_W-1:0] RST_DRIVE_LIMIT = 31'(longint'(1) << FRAC_BITS);
    localparam logic [wmr_pkg::LIMIT_W-1:0] RST_SPEED_LIMIT =
        31'(longint'(1) << (FRAC_BITS - 1));
    localparam logic signed [DW-1:0] DIRECT_MAX = 32'(longint'(29) << (FRAC_BITS - 1));
    localparam logic signed [DW-1:0] DIRECT_MIN = -DIRECT_MAX;
    localparam logic signed [32:0] HALT_MAX =
        33'(((longint'(1) << FRAC_BITS) - 1) / 1000);

    // Saturate a 33-bit signed value to 32 bits.
    function automatic logic signed [DW-1:0] sat32(input logic signed [32:0] x);
        logic signed [DW-1:0] y;
        if (x > 33'(wmr_pkg::MAX32)) begin
            y = wmr_pkg::MAX32;
        end else if (x < 33'(wmr_pkg::MIN32)) begin
            y = wmr_pkg::MIN32;
        end else begin
            y = x[DW-1:0];
        end
        return y;
    endfunction

    // Configuration registers.
    logic signed [DW-1:0]                 r_position_gain;
    logic signed [DW-1:0]                 r_damping_gain;
    logic signed [DW-1:0]                 r_gravity_offset;
    logic [wmr_pkg::LIMIT_W-1:0]          r_drive_limit;
    logic [wmr_pkg::LIMIT_W-1:0]          r_speed_limit;

    // Controller state.
    wmr_pkg::t_state                      r_state, n_state;
    wmr_pkg::t_dir                        r_move_dir, n_move_dir;
    logic                                 r_zero, n_zero;
    logic                                 r_direct, n_direct;
    logic signed [DW-1:0]                 r_held_dd, n_held_dd;
    logic signed [DW-1:0]                 r_held_pos, n_held_pos;
    logic signed [DW-1:0]                 r_held_vel, n_held_vel;
    logic                                 r_skip;
    logic                                 r_halted;
    logic signed [DW-1:0]                 r_pos_target;
    logic signed [DW-1:0]                 r_vel_target;
    logic                                 r_tgt_init;
    logic                                 r_ramp;

    // Working registers of the current item.
    logic [wmr_pkg::DT_W-1:0]             r_dt;
    logic signed [SUM_W-1:0]              r_acc;
    logic signed [DW-1:0]                 r_drive;

    // Output register.
    logic                                 r_out_valid;
    wmr_pkg::t_kind                       r_out_kind;
    logic signed [DW-1:0]                 r_out_a;
    logic signed [DW-1:0]                 r_out_b;

    // Datapath wires.
    wmr_pkg::t_func                       w_func;
    logic                                 w_in_fire;
    logic                                 w_fin_fire;
    logic                                 w_ramp_mode;
    logic signed [DW-1:0]                 w_direct_sat;
    logic signed [DW-1:0]                 w_ramp_vel;
    logic signed [wmr_pkg::MUL_A_W-1:0]   w_mul_a;
    logic signed [wmr_pkg::MUL_B_W-1:0]   w_mul_b;
    logic signed [wmr_pkg::MUL_P_W-1:0]   w_prod;
    logic signed [32:0]                   w_e1;
    logic signed [32:0]                   w_e2;
    logic signed [32:0]                   w_pos_sum;
    logic signed [SUM_W-1:0]              w_prod_shift;
    logic signed [SUM_W-1:0]              w_lim;
    logic signed [DW-1:0]                 w_clamped;
    logic signed [32:0]                   w_grav_diff;
    logic signed [32:0]                   w_mag;
    logic                                 w_halt;

    // Neither channel takes an item while reset is held.
    assign w_func    = wmr_pkg::t_func'(i_in.func);
    assign i_in.ready  = i_rst_n && (r_state == wmr_pkg::S_IDLE);
    assign i_cfg.ready = i_rst_n;
    assign w_in_fire   = i_in.valid && i_in.ready;
    assign w_fin_fire  = (r_state == wmr_pkg::S_FIN) && (!r_out_valid || o_out.ready);

    // Saturate the direct drive request.
    always_comb begin
        if (i_in.direct_current > DIRECT_MAX) begin
            w_direct_sat = DIRECT_MAX;
        end else if (i_in.direct_current < DIRECT_MIN) begin
            w_direct_sat = DIRECT_MIN;
        end else begin
            w_direct_sat = i_in.direct_current;
        end
    end

    // Mode decode and sample capture for an incoming item.
    always_comb begin
        n_zero     = r_zero;
        n_direct   = r_direct;
        n_move_dir = r_move_dir;
        n_held_dd  = r_held_dd;
        unique case (w_func)
            wmr_pkg::FUNC_UP: begin
                n_zero     = 1'b0;
                n_direct   = 1'b0;
                n_move_dir = wmr_pkg::DIR_UP;
            end
            wmr_pkg::FUNC_DOWN: begin
                n_zero     = 1'b0;
                n_direct   = 1'b0;
                n_move_dir = wmr_pkg::DIR_DOWN;
            end
            wmr_pkg::FUNC_STOP: begin
                n_zero     = 1'b0;
                n_direct   = 1'b0;
                n_move_dir = wmr_pkg::DIR_NONE;
            end
            wmr_pkg::FUNC_ZERO: begin
                n_zero   = 1'b1;
                n_direct = 1'b0;
            end
            wmr_pkg::FUNC_DIRECT: begin
                n_zero    = 1'b0;
                n_direct  = 1'b1;
                n_held_dd = w_direct_sat;
            end
            wmr_pkg::FUNC_TIMEOUT: begin
                n_zero     = 1'b0;
                n_move_dir = wmr_pkg::DIR_NONE;
            end
            default: begin
            end
        endcase
        n_held_pos = (i_in.sample_valid && !r_skip) ? i_in.position_in : r_held_pos;
        n_held_vel = i_in.sample_valid ? i_in.velocity_in : r_held_vel;
    end

    assign w_ramp_mode = !n_zero && !n_direct;

    // Velocity ramp step.
    wmr_ramp #(
        .FRAC_BITS     (FRAC_BITS)
    ) u_ramp (
        .i_dir         (r_move_dir),
        .i_vel         (r_vel_target),
        .i_speed_limit (r_speed_limit),
        .i_dt          (r_dt),
        .o_vel         (w_ramp_vel)
    );

    // Errors of the PD law.
    assign w_e1 = 33'(r_held_pos) - 33'(r_pos_target);
    assign w_e2 = 33'(r_held_vel) - 33'(r_vel_target);

    // Shared multiplier.
    wmr_mul u_mul (
        .i_clk (i_clk),
        .i_a   (w_mul_a),
        .i_b   (w_mul_b),
        .o_p   (w_prod)
    );

    // Product terms and clamp of the drive.
    assign w_pos_sum    = 33'(r_pos_target) + 33'($signed(w_prod[47:16]));
    assign w_prod_shift = SUM_W'($signed(w_prod[wmr_pkg::MUL_P_W-1:FRAC_BITS]));
    assign w_lim        = SUM_W'({1'b0, r_drive_limit});

    always_comb begin
        if (r_acc > w_lim) begin
            w_clamped = w_lim[DW-1:0];
        end else if (r_acc < -w_lim) begin
            w_clamped = 32'(-w_lim);
        end else begin
            w_clamped = r_acc[DW-1:0];
        end
    end

    assign w_grav_diff = 33'(w_clamped) - 33'(r_gravity_offset);

    // Halt test on the magnitude of the velocity target.
    assign w_mag  = r_vel_target[DW-1] ? -33'(r_vel_target) : 33'(r_vel_target);
    assign w_halt = r_ramp && (w_mag <= HALT_MAX);

    // Sequencer: next state and multiplier operand selection.
    always_comb begin
        n_state = r_state;
        w_mul_a = r_position_gain;
        w_mul_b = 34'(w_e1);
        unique case (r_state)
            wmr_pkg::S_IDLE: begin
                if (w_in_fire) begin
                    n_state = w_ramp_mode ? wmr_pkg::S_RAMP : wmr_pkg::S_FIN;
                end
            end
            wmr_pkg::S_RAMP: begin
                w_mul_a = w_ramp_vel;
                w_mul_b = 34'({1'b0, r_dt});
                n_state = wmr_pkg::S_POS;
            end
            wmr_pkg::S_POS: begin
                n_state = wmr_pkg::S_ERR_P;
            end
            wmr_pkg::S_ERR_P: begin
                w_mul_a = r_position_gain;
                w_mul_b = 34'(w_e1);
                n_state = wmr_pkg::S_ERR_D;
            end
            wmr_pkg::S_ERR_D: begin
                w_mul_a = r_damping_gain;
                w_mul_b = 34'(w_e2);
                n_state = wmr_pkg::S_SUM;
            end
            wmr_pkg::S_SUM: begin
                n_state = wmr_pkg::S_CLAMP;
            end
            wmr_pkg::S_CLAMP: begin
                n_state = wmr_pkg::S_FIN;
            end
            wmr_pkg::S_FIN: begin
                if (w_fin_fire) begin
                    n_state = wmr_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = wmr_pkg::S_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= wmr_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_position_gain  <= '0;
            r_damping_gain   <= RST_DAMPING;
            r_gravity_offset <= RST_GRAVITY;
            r_drive_limit    <= RST_DRIVE_LIMIT;
            r_speed_limit    <= RST_SPEED_LIMIT;
        end else if (i_cfg.valid && i_cfg.ready) begin
            unique case (i_cfg.index)
                wmr_pkg::CFG_POSITION_GAIN:  r_position_gain  <= $signed(i_cfg.data);
                wmr_pkg::CFG_DAMPING_GAIN:   r_damping_gain   <= $signed(i_cfg.data);
                wmr_pkg::CFG_GRAVITY_OFFSET: r_gravity_offset <= $signed(i_cfg.data);
                wmr_pkg::CFG_DRIVE_LIMIT:    r_drive_limit    <= i_cfg.data[wmr_pkg::LIMIT_W-1:0];
                wmr_pkg::CFG_SPEED_LIMIT:    r_speed_limit    <= i_cfg.data[wmr_pkg::LIMIT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Controller state updates, step by step.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_move_dir   <= wmr_pkg::DIR_NONE;
            r_zero       <= 1'b0;
            r_direct     <= 1'b0;
            r_held_dd    <= '0;
            r_held_pos   <= '0;
            r_held_vel   <= '0;
            r_skip       <= 1'b0;
            r_halted     <= 1'b1;
            r_pos_target <= '0;
            r_vel_target <= '0;
            r_tgt_init   <= 1'b0;
            r_ramp       <= 1'b0;
        end else begin
            unique case (r_state)
                wmr_pkg::S_IDLE: begin
                    if (w_in_fire) begin
                        r_move_dir <= n_move_dir;
                        r_zero     <= n_zero;
                        r_direct   <= n_direct;
                        r_held_dd  <= n_held_dd;
                        r_held_pos <= n_held_pos;
                        r_held_vel <= n_held_vel;
                        r_skip     <= 1'b0;
                        r_ramp     <= w_ramp_mode;
                        // The first ramp tick starts from the held position at rest.
                        if (w_ramp_mode && !r_tgt_init) begin
                            r_pos_target <= n_held_pos;
                            r_vel_target <= '0;
                            r_tgt_init   <= 1'b1;
                        end
                    end
                end
                wmr_pkg::S_RAMP: begin
                    r_vel_target <= w_ramp_vel;
                end
                wmr_pkg::S_POS: begin
                    r_pos_target <= sat32(w_pos_sum);
                end
                wmr_pkg::S_FIN: begin
                    if (w_fin_fire) begin
                        if (w_halt) begin
                            r_pos_target <= r_held_pos;
                            r_halted     <= 1'b1;
                        end else if (r_halted) begin
                            r_halted <= 1'b0;
                            r_skip   <= 1'b1;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Working registers of the item.
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            wmr_pkg::S_IDLE: begin
                r_dt    <= i_in.time_step;
                r_drive <= n_direct ? n_held_dd : '0;
            end
            wmr_pkg::S_ERR_D: begin
                r_acc <= w_prod_shift;
            end
            wmr_pkg::S_SUM: begin
                r_acc <= -(r_acc + w_prod_shift);
            end
            wmr_pkg::S_CLAMP: begin
                r_drive <= sat32(w_grav_diff);
            end
            default: begin
            end
        endcase
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fin_fire) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fin_fire) begin
            if (w_halt) begin
                r_out_kind <= wmr_pkg::KIND_HALT;
            end else if (r_halted) begin
                r_out_kind <= wmr_pkg::KIND_RELEASE;
            end else begin
                r_out_kind <= wmr_pkg::KIND_CURRENT;
            end
            r_out_a <= r_drive;
            r_out_b <= (r_drive == wmr_pkg::MIN32) ? wmr_pkg::MAX32 : -r_drive;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.command_kind = r_out_kind;
    assign o_out.drive_a      = r_out_a;
    assign o_out.drive_b      = r_out_b;

    // Checks on the sequencer and the result.
    `WMR_ASSERT_NEXT(a_accept_leaves_idle, i_clk, i_rst_n, w_in_fire, r_state != wmr_pkg::S_IDLE, "item accepted but sequencer stayed idle")
    `WMR_ASSERT_SAME(a_drive_opposite, i_clk, i_rst_n, o_out.valid, (o_out.drive_b == -o_out.drive_a) || (o_out.drive_a == wmr_pkg::MIN32 && o_out.drive_b == wmr_pkg::MAX32), "drive_b is not the negated drive_a")
    `WMR_ASSERT_NEXT(a_release_skips, i_clk, i_rst_n, w_fin_fire && r_halted && !w_halt, r_skip && !r_halted, "release did not arm the position skip")

endmodule

// ===== rtl/wmr_mul.sv =====
`timescale 1ns / 1ps

// Shared signed multiplier with a registered product.
module wmr_mul (
    input  logic                                  i_clk,
    input  logic signed [wmr_pkg::MUL_A_W-1:0]    i_a,
    input  logic signed [wmr_pkg::MUL_B_W-1:0]    i_b,
    output logic signed [wmr_pkg::MUL_P_W-1:0]    o_p
);

    logic signed [wmr_pkg::MUL_P_W-1:0] r_p;

    // Both operands are signed, so the product is formed at full width.
    always_ff @(posedge i_clk) begin
        r_p <= i_a * i_b;
    end

    assign o_p = r_p;

endmodule

// ===== rtl/wmr_ramp.sv =====
`timescale 1ns / 1ps

// One step of the trapezoidal velocity ramp.
module wmr_ramp #(
    parameter int FRAC_BITS = 16
) (
    input  wmr_pkg::t_dir                        i_dir,
    input  logic signed [wmr_pkg::DATA_W-1:0]    i_vel,
    input  logic [wmr_pkg::LIMIT_W-1:0]          i_speed_limit,
    input  logic [wmr_pkg::DT_W-1:0]             i_dt,
    output logic signed [wmr_pkg::DATA_W-1:0]    o_vel
);

    localparam int UP_W = wmr_pkg::DT_W + FRAC_BITS;
    localparam int DN_W = wmr_pkg::DT_W + 2 + FRAC_BITS;

    logic [UP_W-1:0]                w_up_prod;
    logic [DN_W-1:0]                w_dn_prod;
    logic [wmr_pkg::DT_W+1:0]       w_dt3;
    logic signed [33:0]             w_inc_up;
    logic signed [33:0]             w_inc_dn;
    logic signed [33:0]             w_vel;
    logic signed [33:0]             w_lim;
    logic signed [33:0]             w_lim_neg;
    logic signed [33:0]             w_step;

    // Acceleration 0.5 times dt is a shift; deceleration 3.0 times dt is an add and a shift.
    assign w_up_prod = UP_W'(i_dt) << (FRAC_BITS - 1);
    assign w_inc_up  = 34'(w_up_prod >> wmr_pkg::DT_W);
    assign w_dt3     = {2'b00, i_dt} + {1'b0, i_dt, 1'b0};
    assign w_dn_prod = DN_W'(w_dt3) << FRAC_BITS;
    assign w_inc_dn  = 34'(w_dn_prod >> wmr_pkg::DT_W);

    assign w_vel     = 34'(i_vel);
    assign w_lim     = 34'({1'b0, i_speed_limit});
    assign w_lim_neg = -w_lim;

    // Ramp toward the speed limit, or back toward zero when no move is commanded.
    always_comb begin
        w_step = w_vel;
        unique case (i_dir)
            wmr_pkg::DIR_UP: begin
                if (w_vel < w_lim) begin
                    w_step = w_vel + w_inc_up;
                end
                if (w_step > w_lim) begin
                    w_step = w_lim;
                end
            end
            wmr_pkg::DIR_DOWN: begin
                if (w_vel > w_lim_neg) begin
                    w_step = w_vel - w_inc_up;
                end
                if (w_step < w_lim_neg) begin
                    w_step = w_lim_neg;
                end
            end
            default: begin
                if (w_vel > 34'sd0) begin
                    w_step = w_vel - w_inc_dn;
                    if (w_step < 34'sd0) begin
                        w_step = 34'sd0;
                    end
                end else if (w_vel < 34'sd0) begin
                    w_step = w_vel + w_inc_dn;
                    if (w_step > 34'sd0) begin
                        w_step = 34'sd0;
                    end
                end
            end
        endcase
    end

    assign o_vel = w_step[wmr_pkg::DATA_W-1:0];

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import wmr_pkg::*;

    localparam int          FRAC          = 16;
    localparam int          ITEMS_PER_SET = 250;
    localparam int          SETTING_COUNT = 6;
    localparam int unsigned LIMIT_CYCLES  = 400000;
    localparam int          HOLD_CYCLES   = 400;
    localparam int          TAIL_CYCLES   = 16;

    // Mode code beyond the documented list; the block treats it like unknown.
    localparam logic [FUNC_W-1:0] FUNC_RESERVED = 3'd7;

    localparam longint I32_MAX    = 64'sd2147483647;
    localparam longint I32_MIN    = -64'sd2147483648;
    localparam longint ONE_Q      = longint'(1) << FRAC;
    localparam longint ACC_UP     = longint'(1) << (FRAC - 1);
    localparam longint ACC_DOWN   = longint'(3) << FRAC;
    localparam longint DIRECT_LIM = longint'(29) << (FRAC - 1);

    // One control tick as offered on the input channel.
    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [DATA_W-1:0] direct_current;
        logic              sample_valid;
        logic [DATA_W-1:0] position_in;
        logic [DATA_W-1:0] velocity_in;
        logic [DT_W-1:0]   time_step;
    } tick_in_t;

    // One motor command as returned on the output channel.
    typedef struct packed {
        t_kind             kind;
        logic [DATA_W-1:0] drive_a;
        logic [DATA_W-1:0] drive_b;
    } motor_cmd_t;

    // Directed stimulus row; a fixed row carries a hand-written expectation.
    typedef struct packed {
        tick_in_t   tick;
        logic       fixed;
        motor_cmd_t want;
    } dir_row_t;

    logic i_clk;
    logic i_rst_n;

    wmr_in_if  in_ch ();
    wmr_out_if out_ch ();
    wmr_cfg_if cfg_ch ();

    waist_motor_ramp_pd_controller_core #(
        .FRAC_BITS(FRAC)
    ) u_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch),
        .o_out  (out_ch),
        .i_cfg  (cfg_ch)
    );

    // Predicted copy of the configuration registers.
    longint kp_q, kd_q, grav_q, drv_lim_q, spd_lim_q;

    // Predicted copy of the controller state.
    t_dir   st_dir;
    logic   st_zero, st_direct, st_skip, st_halted, st_tgt_init;
    longint st_hold_cur, st_pos, st_vel, st_tgt_pos, st_tgt_vel;

    motor_cmd_t expected_cmds[$];
    dir_row_t   dir_table[$];

    int          fails = 0;
    int          items_sent = 0;
    int          results_seen = 0;
    int          cfg_writes = 0;
    int          kind_tally[4] = '{0, 0, 0, 0};
    int unsigned src_idle_pct = 8;
    int unsigned sink_idle_pct = 66;

    // Current random move command and how many more ticks it lasts.
    logic [FUNC_W-1:0] run_func = FUNC_STOP;
    int                run_left = 0;

    // Clock generation.
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Saturate to the signed 32-bit range.
    function automatic longint clip32(longint x);
        if (x > I32_MAX) return I32_MAX;
        if (x < I32_MIN) return I32_MIN;
        return x;
    endfunction

    // Uniform value in [-span, span], two's complement.
    function automatic logic [DATA_W-1:0] around_zero(int unsigned span);
        return $urandom_range(0, 2 * span) - span;
    endfunction

    // Advance the predicted state by one tick and return the command it produces.
    function automatic motor_cmd_t predict_command(tick_in_t t);
        longint     dt, v, e_pos, e_vel, cur, drv, mag, neg;
        motor_cmd_t r;
        dt  = longint'(t.time_step);
        drv = 0;

        // Mode command.
        case (t.func)
            FUNC_UP, FUNC_DOWN, FUNC_STOP: begin
                st_zero   = 1'b0;
                st_direct = 1'b0;
                st_dir    = (t.func == FUNC_UP) ? DIR_UP :
                            (t.func == FUNC_DOWN) ? DIR_DOWN : DIR_NONE;
            end
            FUNC_ZERO: begin
                st_zero   = 1'b1;
                st_direct = 1'b0;
            end
            FUNC_DIRECT: begin
                st_zero     = 1'b0;
                st_direct   = 1'b1;
                st_hold_cur = longint'($signed(t.direct_current));
                if (st_hold_cur > DIRECT_LIM) st_hold_cur = DIRECT_LIM;
                if (st_hold_cur < -DIRECT_LIM) st_hold_cur = -DIRECT_LIM;
            end
            FUNC_TIMEOUT: begin
                st_zero = 1'b0;
                st_dir  = DIR_NONE;
            end
            default: ;
        endcase

        // Sample capture; the position is dropped once right after a release.
        if (t.sample_valid) begin
            if (!st_skip) st_pos = longint'($signed(t.position_in));
            st_vel = longint'($signed(t.velocity_in));
        end
        st_skip = 1'b0;

        if (!st_zero && !st_direct) begin
            if (!st_tgt_init) begin
                st_tgt_pos  = st_pos;
                st_tgt_vel  = 0;
                st_tgt_init = 1'b1;
            end
            // Velocity ramp toward the commanded limit, or back to zero.
            v = st_tgt_vel;
            case (st_dir)
                DIR_UP: begin
                    if (v < spd_lim_q) v += (ACC_UP * dt) >>> 16;
                    if (v > spd_lim_q) v = spd_lim_q;
                end
                DIR_DOWN: begin
                    if (v > -spd_lim_q) v -= (ACC_UP * dt) >>> 16;
                    if (v < -spd_lim_q) v = -spd_lim_q;
                end
                default: begin
                    if (v > 0) begin
                        v -= (ACC_DOWN * dt) >>> 16;
                        if (v < 0) v = 0;
                    end else if (v < 0) begin
                        v += (ACC_DOWN * dt) >>> 16;
                        if (v > 0) v = 0;
                    end
                end
            endcase
            st_tgt_vel = v;
            st_tgt_pos = clip32(st_tgt_pos + ((v * dt) >>> 16));

            // PD law, clamp, then gravity compensation.
            e_pos = st_pos - st_tgt_pos;
            e_vel = st_vel - st_tgt_vel;
            cur   = -(((kp_q * e_pos) >>> FRAC) + ((kd_q * e_vel) >>> FRAC));
            if (cur > drv_lim_q) cur = drv_lim_q;
            if (cur < -drv_lim_q) cur = -drv_lim_q;
            drv = clip32(cur - grav_q);
        end else if (st_direct) begin
            drv = st_hold_cur;
        end

        // Halt, release or plain current.
        mag = (st_tgt_vel < 0) ? -st_tgt_vel : st_tgt_vel;
        if (!st_zero && !st_direct && mag * 1000 < ONE_Q) begin
            r.kind     = KIND_HALT;
            st_tgt_pos = st_pos;
            st_halted  = 1'b1;
        end else if (st_halted) begin
            r.kind    = KIND_RELEASE;
            st_halted = 1'b0;
            st_skip   = 1'b1;
        end else begin
            r.kind = KIND_CURRENT;
        end

        neg       = clip32(-drv);
        r.drive_a = drv[DATA_W-1:0];
        r.drive_b = neg[DATA_W-1:0];
        return r;
    endfunction

    // Build a directed row.
    function automatic dir_row_t mk(logic [FUNC_W-1:0] f, logic [DATA_W-1:0] cur,
                                    logic smp, logic [DATA_W-1:0] pos,
                                    logic [DATA_W-1:0] vel, logic [DT_W-1:0] dt,
                                    logic fixed = 1'b0, t_kind k = KIND_HALT,
                                    logic [DATA_W-1:0] a = '0,
                                    logic [DATA_W-1:0] b = '0);
        dir_row_t r;
        r.tick.func           = f;
        r.tick.direct_current = cur;
        r.tick.sample_valid   = smp;
        r.tick.position_in    = pos;
        r.tick.velocity_in    = vel;
        r.tick.time_step      = dt;
        r.fixed               = fixed;
        r.want.kind           = k;
        r.want.drive_a        = a;
        r.want.drive_b        = b;
        return r;
    endfunction

    // Random tick: move commands come in runs so the ramp builds up and winds down.
    function automatic tick_in_t random_tick();
        tick_in_t    t;
        int unsigned r;
        if (run_left == 0) begin
            r = $urandom_range(0, 99);
            if (r < 30)      run_func = FUNC_UP;
            else if (r < 60) run_func = FUNC_DOWN;
            else if (r < 78) run_func = FUNC_STOP;
            else if (r < 83) run_func = FUNC_ZERO;
            else if (r < 88) run_func = FUNC_DIRECT;
            else if (r < 93) run_func = FUNC_TIMEOUT;
            else if (r < 97) run_func = FUNC_UNKNOWN;
            else             run_func = FUNC_RESERVED;
            run_left = $urandom_range(1, 12);
        end
        run_left--;
        t.func = run_func;

        case ($urandom_range(0, 3))
            0:       t.direct_current = $urandom;
            default: t.direct_current = around_zero(20 << 16);
        endcase
        t.sample_valid = ($urandom_range(0, 9) < 8);
        case ($urandom_range(0, 9))
            0:       t.position_in = $urandom;
            1:       t.position_in = MAX32 - $urandom_range(0, 65535);
            2:       t.position_in = MIN32 + $urandom_range(0, 65535);
            default: t.position_in = around_zero(4 << 16);
        endcase
        case ($urandom_range(0, 9))
            0:       t.velocity_in = $urandom;
            default: t.velocity_in = around_zero(1 << 16);
        endcase
        case ($urandom_range(0, 19))
            0:       t.time_step = '0;
            1:       t.time_step = '1;
            2, 3:    t.time_step = $urandom;
            default: t.time_step = $urandom_range(300, 1000);
        endcase
        return t;
    endfunction

    // Offer one tick, idling at random beforehand, and return once it is accepted.
    task automatic offer_tick(tick_in_t t);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid          <= 1'b1;
        in_ch.func           <= t.func;
        in_ch.direct_current <= t.direct_current;
        in_ch.sample_valid   <= t.sample_valid;
        in_ch.position_in    <= t.position_in;
        in_ch.velocity_in    <= t.velocity_in;
        in_ch.time_step      <= t.time_step;
        do @(posedge i_clk); while (!in_ch.ready);
        items_sent++;
    endtask

    // Write one register; the caller lowers valid after the last write.
    task automatic write_reg(t_cfg_idx idx, logic [DATA_W-1:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do @(posedge i_clk); while (!cfg_ch.ready);
        case (idx)
            CFG_POSITION_GAIN:  kp_q = longint'($signed(value));
            CFG_DAMPING_GAIN:   kd_q = longint'($signed(value));
            CFG_GRAVITY_OFFSET: grav_q = longint'($signed(value));
            CFG_DRIVE_LIMIT:    drv_lim_q = longint'(value[LIMIT_W-1:0]);
            CFG_SPEED_LIMIT:    spd_lim_q = longint'(value[LIMIT_W-1:0]);
            default: ;
        endcase
        cfg_writes++;
    endtask

    // Stop offering and wait until every predicted command has come back.
    task automatic wait_all_results();
        in_ch.valid <= 1'b0;
        while (expected_cmds.size() != 0) @(posedge i_clk);
    endtask

    // Result side: random back-pressure, two long stalls, and the field checks.
    initial begin : result_side
        motor_cmd_t want;
        int         hold_left;
        hold_left    = 0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (out_ch.valid && out_ch.ready) begin
                if (expected_cmds.size() == 0) begin
                    $display("%0t: unexpected result, expected none, got kind %0d a %0d b %0d",
                             $time, out_ch.command_kind, $signed(out_ch.drive_a),
                             $signed(out_ch.drive_b));
                    fails++;
                end else begin
                    want = expected_cmds.pop_front();
                    if (out_ch.command_kind !== want.kind) begin
                        $display("%0t: command_kind mismatch, expected %0d, got %0d",
                                 $time, want.kind, out_ch.command_kind);
                        fails++;
                    end
                    if (out_ch.drive_a !== want.drive_a) begin
                        $display("%0t: drive_a mismatch, expected %0d, got %0d",
                                 $time, $signed(want.drive_a), $signed(out_ch.drive_a));
                        fails++;
                    end
                    if (out_ch.drive_b !== want.drive_b) begin
                        $display("%0t: drive_b mismatch, expected %0d, got %0d",
                                 $time, $signed(want.drive_b), $signed(out_ch.drive_b));
                        fails++;
                    end
                end
                kind_tally[out_ch.command_kind]++;
                results_seen++;
                // Long stalls so the block fills up and holds off its input.
                if (results_seen == 300 || results_seen == 1000) hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= ($urandom_range(0, 99) >= sink_idle_pct);
            end
        end
    end

    // Watchdog on the total run length.
    initial begin : watchdog
        int unsigned n;
        n = 0;
        while (n < LIMIT_CYCLES) begin
            @(posedge i_clk);
            n++;
        end
        $display("%0t: run did not finish within %0d cycles", $time, LIMIT_CYCLES);
        $display("CHECK FAILED");
        $finish;
    end

    // Main sequence: reset, directed table, then random ticks over several settings.
    initial begin : main_seq
        dir_row_t          row;
        tick_in_t          t;
        motor_cmd_t        want;
        logic [DATA_W-1:0] vals[5];

        i_rst_n              <= 1'b0;
        in_ch.valid          <= 1'b0;
        in_ch.func           <= FUNC_STOP;
        in_ch.direct_current <= '0;
        in_ch.sample_valid   <= 1'b0;
        in_ch.position_in    <= '0;
        in_ch.velocity_in    <= '0;
        in_ch.time_step      <= '0;
        cfg_ch.valid         <= 1'b0;
        cfg_ch.index         <= CFG_POSITION_GAIN;
        cfg_ch.data          <= '0;

        // Predicted state after reset.
        kp_q        = 0;
        kd_q        = longint'(10) << FRAC;
        grav_q      = (1027 * ONE_Q + 500) / 1000;
        drv_lim_q   = ONE_Q;
        spd_lim_q   = ONE_Q >> 1;
        st_dir      = DIR_NONE;
        st_zero     = 1'b0;
        st_direct   = 1'b0;
        st_hold_cur = 0;
        st_pos      = 0;
        st_vel      = 0;
        st_skip     = 1'b0;
        st_halted   = 1'b1;
        st_tgt_pos  = 0;
        st_tgt_vel  = 0;
        st_tgt_init = 1'b0;

        // Directed rows. The first four follow straight from the reset values.
        dir_table.push_back(mk(FUNC_STOP, '0, 1'b0, '0, '0, '0,
                               1'b1, KIND_HALT, -32'sd67305, 32'sd67305));
        dir_table.push_back(mk(FUNC_ZERO, '0, 1'b0, '0, '0, 16'd100,
                               1'b1, KIND_RELEASE, '0, '0));
        // Sample right after the release: the position must be ignored.
        dir_table.push_back(mk(FUNC_DIRECT, MAX32, 1'b1, MAX32, MIN32, '1,
                               1'b1, KIND_CURRENT, 32'sd950272, -32'sd950272));
        dir_table.push_back(mk(FUNC_DIRECT, MIN32, 1'b0, '0, '0, '0,
                               1'b1, KIND_CURRENT, -32'sd950272, 32'sd950272));
        dir_table.push_back(mk(FUNC_DIRECT, 32'sd123456, 1'b1, 32'sd65536, '0, 16'd655));
        // Timeout keeps direct drive; unknown and reserved codes change nothing.
        dir_table.push_back(mk(FUNC_TIMEOUT, '0, 1'b0, '0, '0, 16'd655));
        dir_table.push_back(mk(FUNC_UNKNOWN, MAX32, 1'b1, MIN32, MAX32, '1));
        dir_table.push_back(mk(FUNC_RESERVED, MIN32, 1'b1, 32'sd1000, '0, 16'd655));
        // Ramp up to the speed limit and beyond, then coast, reverse and stop.
        dir_table.push_back(mk(FUNC_UP, '0, 1'b1, '0, '0, '1));
        dir_table.push_back(mk(FUNC_UP, '0, 1'b0, '0, '0, '1));
        dir_table.push_back(mk(FUNC_UP, '0, 1'b1, 32'sd20000, 32'sd30000, '1));
        dir_table.push_back(mk(FUNC_TIMEOUT, '0, 1'b0, '0, '0, 16'd655));
        dir_table.push_back(mk(FUNC_DOWN, '0, 1'b0, '0, '0, '1));
        dir_table.push_back(mk(FUNC_DOWN, '0, 1'b1, -32'sd5000, -32'sd30000, '1));
        dir_table.push_back(mk(FUNC_DOWN, '0, 1'b0, '0, '0, '1));
        dir_table.push_back(mk(FUNC_STOP, '0, 1'b0, '0, '0, '1));
        dir_table.push_back(mk(FUNC_STOP, '0, 1'b0, '0, '0, '0));
        dir_table.push_back(mk(FUNC_UP, '0, 1'b0, '0, '0, '0));
        // Move out of a halt, then samples on the tick after the release and the one after that.
        dir_table.push_back(mk(FUNC_UP, '0, 1'b0, '0, '0, 16'd655));
        dir_table.push_back(mk(FUNC_UP, '0, 1'b1, 32'sh0004_0000, 32'sh0000_8000, 16'd655));
        dir_table.push_back(mk(FUNC_UP, '0, 1'b1, 32'sh0004_0000, 32'sh0000_8000, 16'd655));
        dir_table.push_back(mk(FUNC_ZERO, '0, 1'b1, MAX32, MAX32, 16'd655));
        dir_table.push_back(mk(FUNC_DIRECT, '0, 1'b0, '0, '0, '0));
        dir_table.push_back(mk(FUNC_STOP, '0, 1'b1, MIN32, MIN32, '1));

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part.
        foreach (dir_table[i]) begin
            row = dir_table[i];
            offer_tick(row.tick);
            want = predict_command(row.tick);
            if (row.fixed) want = row.want;
            expected_cmds.push_back(want);
        end

        // Random part over several register settings and idling patterns.
        for (int phase = 0; phase < SETTING_COUNT; phase++) begin
            if (phase > 0) begin
                wait_all_results();
                case (phase)
                    1: vals = '{MAX32, MAX32, MIN32, 32'hFFFF_FFFF, 32'hFFFF_FFFF};
                    2: vals = '{MIN32, MIN32, MAX32, 32'h0, 32'h0};
                    3: vals = '{MAX32, MAX32, 32'h1, 32'h7FFF_FFFF, 32'h7FFF_FFFF};
                    default: begin
                        for (int k = 0; k < 3; k++)
                            vals[k] = ($urandom_range(0, 3) == 0) ? $urandom :
                                                                    around_zero(40 << 16);
                        for (int k = 3; k < 5; k++)
                            vals[k] = ($urandom_range(0, 3) == 0) ? $urandom :
                                                                    $urandom_range(0, 3 << 16);
                    end
                endcase
                for (int k = 0; k < 5; k++) write_reg(t_cfg_idx'(k), vals[k]);
                // Unused indexes must leave every register alone.
                if (phase >= 4)
                    write_reg(t_cfg_idx'($urandom_range(5, 7)), $urandom);
                cfg_ch.valid <= 1'b0;
            end

            case (phase / 2)
                0: begin src_idle_pct = 8;  sink_idle_pct = 66; end
                1: begin src_idle_pct = 66; sink_idle_pct = 8;  end
                default: begin src_idle_pct = 0; sink_idle_pct = 0; end
            endcase

            repeat (ITEMS_PER_SET) begin
                t = random_tick();
                offer_tick(t);
                expected_cmds.push_back(predict_command(t));
            end
        end

        wait_all_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Ran %0d ticks (%0d directed) with %0d register writes over %0d settings.",
                 items_sent, dir_table.size(), cfg_writes, SETTING_COUNT);
        $display("Checked %0d commands: %0d halt, %0d release, %0d current, %0d failures.",
                 results_seen, kind_tally[KIND_HALT], kind_tally[KIND_RELEASE],
                 kind_tally[KIND_CURRENT], fails);
        if (fails == 0 && expected_cmds.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
